[hdl/mmcm_pkg.sv]
// Package for the ADC block min/max/clip monitor.
// Shared constants, register codes and lane/config types; no dependencies.
package mmcm_pkg;

  localparam int unsigned STREAMS     = 6;
  localparam int unsigned CODE_W      = 16;
  localparam int unsigned IDX_W       = $clog2(STREAMS);
  localparam int unsigned MAX_SAMPLES = 256;
  localparam int unsigned CNT_W       = $clog2(MAX_SAMPLES + 2);
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned IN_W        = STREAMS * CODE_W;
  localparam int unsigned OUT_W       = 40;

  localparam logic [CODE_W-1:0] NO_MIN          = 16'hFFFF;
  localparam logic [CODE_W-1:0] NO_MAX          = 16'h0000;
  localparam logic [CODE_W-1:0] RST_DATA_MASK   = 16'h0FFF;
  localparam logic [CODE_W-1:0] RST_CLIP_LOW    = 16'h0000;
  localparam logic [CODE_W-1:0] RST_CLIP_HIGH   = 16'h0FFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DATA_MASK = 2'd0,
    REG_CLIP_LOW  = 2'd1,
    REG_CLIP_HIGH = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [CODE_W-1:0] data_mask;
    logic [CODE_W-1:0] clip_low;
    logic [CODE_W-1:0] clip_high;
  } cfg_t;

  typedef struct packed {
    logic [CODE_W-1:0] min_code;
    logic [CODE_W-1:0] max_code;
    logic              clip;
  } lane_stat_t;

endpackage

[hdl/mmcm_lane.sv]
// One stream lane: masks a 16-bit half, tracks running min, max and clip.
// Depends on mmcm_pkg. stat_o is the state including the current sample.
module mmcm_lane
  import mmcm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic [CODE_W-1:0] half_i,
  input  logic              upd_i,
  input  logic              clr_i,
  output lane_stat_t        stat_o
);

  lane_stat_t        stat_q, stat_d;
  logic [CODE_W-1:0] code;

  always_comb begin
    code   = half_i & cfg_i.data_mask;
    stat_d = stat_q;
    if (upd_i) begin
      if (code < stat_q.min_code) stat_d.min_code = code;
      if (code > stat_q.max_code) stat_d.max_code = code;
      if ((code <= cfg_i.clip_low) || (code >= cfg_i.clip_high)) stat_d.clip = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_q <= '{min_code: NO_MIN, max_code: NO_MAX, clip: 1'b0};
    end else if (clr_i) begin
      stat_q <= '{min_code: NO_MIN, max_code: NO_MAX, clip: 1'b0};
    end else begin
      stat_q <= stat_d;
    end
  end

  assign stat_o = stat_d;

endmodule

[hdl/mmcm_merge.sv]
// Merge stage: snapshots all lanes at block end and sends six result words.
// Depends on mmcm_pkg. tdata: min, max, stream_clipped, any_clipped, overlong.
module mmcm_merge
  import mmcm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  lane_stat_t        lanes_i [STREAMS],
  input  logic              over_i,
  output logic              free_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata,
  output logic [IDX_W-1:0]  m_axis_tuser,
  output logic              m_axis_tlast
);

  logic                    busy_q, busy_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  lane_stat_t              snap_q [STREAMS];
  logic                    any_q, over_q;
  logic                    any_clip;
  logic                    last_idx;
  logic                    last_beat;

  always_comb begin
    any_clip = 1'b0;
    for (int s = 0; s < STREAMS; s++) any_clip = any_clip | lanes_i[s].clip;
  end

  assign last_idx  = (idx_q == IDX_W'(STREAMS - 1));
  assign last_beat = busy_q & m_axis_tready & last_idx;
  assign free_o    = ~busy_q | last_beat;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (load_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (busy_q && m_axis_tready) begin
      if (last_idx) busy_d = 1'b0;
      else          idx_d  = idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  // overlong blocks report reset values
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int s = 0; s < STREAMS; s++) begin
        if (over_i) snap_q[s] <= '{min_code: NO_MIN, max_code: NO_MAX, clip: 1'b0};
        else        snap_q[s] <= lanes_i[s];
      end
      any_q  <= any_clip & ~over_i;
      over_q <= over_i;
    end
  end

  assign m_axis_tvalid = busy_q;
  assign m_axis_tuser  = idx_q;
  assign m_axis_tlast  = last_idx;
  assign m_axis_tdata  = {5'b0, over_q, any_q, snap_q[idx_q].clip,
                          snap_q[idx_q].max_code, snap_q[idx_q].min_code};

endmodule

[hdl/adc_block_min_max_clip_monitor.sv]
// ADC block min/max/clip monitor. Takes one sample (six 16-bit ADC codes in three
// 32-bit words) per clock cycle; six lanes track min, max and hard clip in parallel.
// The sample with tlast set closes the block: its stats are snapshotted and
// sent as six result words while the next block's samples keep flowing in. A
// closing sample waits only while the previous block's six words have not all
// been taken. Blocks over MAX_SAMPLES samples report reset stats with overlong.
// Depends on mmcm_pkg, mmcm_lane, mmcm_merge.
module adc_block_min_max_clip_monitor
  import mmcm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CODE_W-1:0]    cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // word_first [31:0], word_second [63:32], word_third [95:64]
  input  logic [IN_W-1:0]      s_axis_tdata,
  input  logic                 s_axis_tlast,   // block_end
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // min_code [15:0], max_code [31:16], stream_clipped [32], any_clipped [33],
  // overlong [34], zero [39:35]
  output logic [OUT_W-1:0]     m_axis_tdata,
  output logic [IDX_W-1:0]     m_axis_tuser,   // stream_index
  output logic                 m_axis_tlast    // final_result
);

  cfg_t             cfg_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             accept, upd, over, clr, free;
  lane_stat_t       lane_stat [STREAMS];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{data_mask: RST_DATA_MASK, clip_low: RST_CLIP_LOW,
                 clip_high: RST_CLIP_HIGH};
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_DATA_MASK: cfg_q.data_mask <= cfg_data_i;
        REG_CLIP_LOW:  cfg_q.clip_low  <= cfg_data_i;
        REG_CLIP_HIGH: cfg_q.clip_high <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = ~s_axis_tlast | free;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign upd           = accept & (cnt_q < CNT_W'(MAX_SAMPLES));
  assign over          = (cnt_q >= CNT_W'(MAX_SAMPLES));
  assign clr           = accept & s_axis_tlast;

  always_comb begin
    cnt_d = cnt_q;
    if (clr)                                             cnt_d = '0;
    else if (accept && cnt_q <= CNT_W'(MAX_SAMPLES))     cnt_d = cnt_q + CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else         cnt_q <= cnt_d;
  end

  for (genvar g = 0; g < STREAMS; g++) begin : g_lane
    mmcm_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cfg_i  (cfg_q),
      .half_i (s_axis_tdata[g*CODE_W +: CODE_W]),
      .upd_i  (upd),
      .clr_i  (clr),
      .stat_o (lane_stat[g])
    );
  end

  mmcm_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (clr),
    .lanes_i       (lane_stat),
    .over_i        (over),
    .free_o        (free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

[hdl/mmcm_checker.sv]
// Port-level checker for the ADC block min/max/clip monitor, bound to the top.
// Depends on mmcm_pkg.
module mmcm_checker
  import mmcm_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OUT_W-1:0]     m_axis_tdata,
  input logic [IDX_W-1:0]     m_axis_tuser,
  input logic                 m_axis_tlast
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result word changed");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == IDX_W'(STREAMS - 1))))
    else $error("final flag not on last stream");

  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && (m_axis_tuser == IDX_W'($past(m_axis_tuser) + IDX_W'(1))))
    else $error("result words out of stream order");

  a_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[34] |-> (m_axis_tdata[15:0] == NO_MIN)
      && (m_axis_tdata[31:16] == NO_MAX) && !m_axis_tdata[32] && !m_axis_tdata[33])
    else $error("overlong block carries stats");

  a_any: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[33])
    else $error("stream clip without block clip");

endmodule

bind adc_block_min_max_clip_monitor mmcm_checker u_mmcm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
